FILE: src/afft_pkg.sv
// Shared widths and register index codes for the 3-D affine point transform.
package afft_pkg;

  // Fixed field and register widths
  localparam int FIELD_W    = 32;
  localparam int COEF_W     = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_ROWS   = 3;
  localparam int NUM_COLS   = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5
  } reg_idx_t;

endpackage

FILE: src/affine_point_transform_3d.sv
// Top level of the 3-D affine point transform: config registers and a three-stage pipeline.
//
// Applies a 3x4 affine matrix (implicit w = 1) to one point per clock. A point is taken
// whenever start is high and busy is low; busy is high only during reset and in the cycle
// after it, so a new point can be offered every cycle. A point passes through the input
// register, then the nine product registers (32 x COORD_WIDTH signed multipliers, one per
// coefficient), then the exact sum, round-half-up and saturation into the result register,
// which is loaded together with the out_valid strobe. out_valid lasts one cycle and the
// receiver cannot stall it, so results must be taken as they come. The matrix resets to
// identity and is written through the cfg port, which is always ready; write it only while
// no point is in flight. Indexes six and seven are ignored.
module affine_point_transform_3d #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Point channel
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [afft_pkg::FIELD_W-1:0]      in_point_x,
  input  logic signed [afft_pkg::FIELD_W-1:0]      in_point_y,
  input  logic signed [afft_pkg::FIELD_W-1:0]      in_point_z,
  // Result channel
  output logic                                     out_valid,
  output logic signed [afft_pkg::FIELD_W-1:0]      out_moved_x,
  output logic signed [afft_pkg::FIELD_W-1:0]      out_moved_y,
  output logic signed [afft_pkg::FIELD_W-1:0]      out_moved_z,
  // Configuration write channel
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [afft_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [afft_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int PROD_W = afft_pkg::COEF_W + COORD_WIDTH;
  localparam int TRN_W  = afft_pkg::COEF_W + FRAC_BITS;
  localparam int SUM_W  = ((PROD_W > TRN_W) ? PROD_W : TRN_W) + 3;

  localparam logic [afft_pkg::COEF_W-1:0] ONE = afft_pkg::COEF_W'(64'd1 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'((64'd1 << FRAC_BITS) >> 1);
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic                                  busy_r;
  logic [afft_pkg::CFG_DATA_W-1:0]       mat_r [6];
  logic                                  v0_r, v1_r, out_valid_r;
  logic signed [COORD_WIDTH-1:0]         pt_r [afft_pkg::NUM_COLS];
  logic signed [afft_pkg::COEF_W-1:0]    coef [afft_pkg::NUM_ROWS][afft_pkg::NUM_COLS];
  logic signed [afft_pkg::COEF_W-1:0]    trn [afft_pkg::NUM_ROWS];
  logic signed [PROD_W-1:0]              prod_nxt [afft_pkg::NUM_ROWS][afft_pkg::NUM_COLS];
  logic signed [PROD_W-1:0]              prod_r [afft_pkg::NUM_ROWS][afft_pkg::NUM_COLS];
  logic signed [SUM_W-1:0]               sum [afft_pkg::NUM_ROWS];
  logic signed [SUM_W-1:0]               rnd [afft_pkg::NUM_ROWS];
  logic signed [COORD_WIDTH-1:0]         sat [afft_pkg::NUM_ROWS];
  logic signed [afft_pkg::FIELD_W-1:0]   moved_nxt [afft_pkg::NUM_ROWS];
  logic signed [afft_pkg::FIELD_W-1:0]   moved_r [afft_pkg::NUM_ROWS];
  logic                                  accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Hold off points only during reset and in the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Matrix registers: reset to identity, write by index, drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[afft_pkg::REG_ROW0_C01] <= {32'd0, ONE};
      mat_r[afft_pkg::REG_ROW0_C23] <= '0;
      mat_r[afft_pkg::REG_ROW1_C01] <= {ONE, 32'd0};
      mat_r[afft_pkg::REG_ROW1_C23] <= '0;
      mat_r[afft_pkg::REG_ROW2_C01] <= '0;
      mat_r[afft_pkg::REG_ROW2_C23] <= {32'd0, ONE};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afft_pkg::REG_ROW0_C01: mat_r[afft_pkg::REG_ROW0_C01] <= cfg_data;
        afft_pkg::REG_ROW0_C23: mat_r[afft_pkg::REG_ROW0_C23] <= cfg_data;
        afft_pkg::REG_ROW1_C01: mat_r[afft_pkg::REG_ROW1_C01] <= cfg_data;
        afft_pkg::REG_ROW1_C23: mat_r[afft_pkg::REG_ROW1_C23] <= cfg_data;
        afft_pkg::REG_ROW2_C01: mat_r[afft_pkg::REG_ROW2_C01] <= cfg_data;
        afft_pkg::REG_ROW2_C23: mat_r[afft_pkg::REG_ROW2_C23] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack coefficients and translations, low half is the lower column
  always_comb begin
    coef[0][0] = mat_r[afft_pkg::REG_ROW0_C01][31:0];
    coef[0][1] = mat_r[afft_pkg::REG_ROW0_C01][63:32];
    coef[0][2] = mat_r[afft_pkg::REG_ROW0_C23][31:0];
    trn[0]     = mat_r[afft_pkg::REG_ROW0_C23][63:32];
    coef[1][0] = mat_r[afft_pkg::REG_ROW1_C01][31:0];
    coef[1][1] = mat_r[afft_pkg::REG_ROW1_C01][63:32];
    coef[1][2] = mat_r[afft_pkg::REG_ROW1_C23][31:0];
    trn[1]     = mat_r[afft_pkg::REG_ROW1_C23][63:32];
    coef[2][0] = mat_r[afft_pkg::REG_ROW2_C01][31:0];
    coef[2][1] = mat_r[afft_pkg::REG_ROW2_C01][63:32];
    coef[2][2] = mat_r[afft_pkg::REG_ROW2_C23][31:0];
    trn[2]     = mat_r[afft_pkg::REG_ROW2_C23][63:32];
  end

  // Stage control: advance the valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= accept;
      v1_r        <= v0_r;
      out_valid_r <= v1_r;
    end
  end

  // Input register: keep the low COORD_WIDTH bits of each coordinate
  always_ff @(posedge clk) begin
    if (accept) begin
      pt_r[0] <= in_point_x[COORD_WIDTH-1:0];
      pt_r[1] <= in_point_y[COORD_WIDTH-1:0];
      pt_r[2] <= in_point_z[COORD_WIDTH-1:0];
    end
  end

  // Form the nine exact products
  always_comb begin
    for (int r = 0; r < afft_pkg::NUM_ROWS; r++) begin
      for (int k = 0; k < afft_pkg::NUM_COLS; k++) begin
        prod_nxt[r][k] = PROD_W'(PROD_W'(coef[r][k]) * PROD_W'(pt_r[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Sum exactly, round half up, saturate, sign-extend to the field width
  always_comb begin
    for (int r = 0; r < afft_pkg::NUM_ROWS; r++) begin
      sum[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2])
             + (SUM_W'(trn[r]) <<< FRAC_BITS) + HALF;
      rnd[r] = sum[r] >>> FRAC_BITS;
      if (rnd[r] > SAT_HI) begin
        sat[r] = SAT_HI[COORD_WIDTH-1:0];
      end else if (rnd[r] < SAT_LO) begin
        sat[r] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        sat[r] = rnd[r][COORD_WIDTH-1:0];
      end
      moved_nxt[r] = afft_pkg::FIELD_W'(sat[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      moved_r <= moved_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_moved_x = moved_r[0];
  assign out_moved_y = moved_r[1];
  assign out_moved_z = moved_r[2];

  // Every accepted item leaves with a result strobe on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted item did not produce a result after three cycles");

  // A result strobe needs an item in the product stage the cycle before
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v1_r))
    else $error("result strobe without an item in the product stage");

  // Saturated results are sign-extended from COORD_WIDTH bits
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_moved_x == afft_pkg::FIELD_W'($signed(out_moved_x[COORD_WIDTH-1:0])))
   && (out_moved_y == afft_pkg::FIELD_W'($signed(out_moved_y[COORD_WIDTH-1:0])))
   && (out_moved_z == afft_pkg::FIELD_W'($signed(out_moved_z[COORD_WIDTH-1:0]))))
    else $error("result outside the saturated coordinate range");

  // Once out of reset the block takes an item every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised after reset");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the 3-D affine point transform.
module testbench;

  localparam int FRAC       = 16;
  localparam int CWIDTH     = 32;
  localparam int NUM_REGS   = afft_pkg::NUM_ROWS * 2;
  localparam int PIPE_DEPTH = 3;
  localparam int PHASE_PTS  = 125;
  localparam int MAX_PRINTS = 40;

  // Indexes past the matrix registers, which the block must ignore
  localparam logic [afft_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [afft_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_HALF = 32'h0000_8000;

  localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
  localparam logic signed [79:0] SAT_LO = -SAT_HI - 80'sd1;

  typedef struct packed {
    logic signed [afft_pkg::FIELD_W-1:0] x;
    logic signed [afft_pkg::FIELD_W-1:0] y;
    logic signed [afft_pkg::FIELD_W-1:0] z;
  } point_t;

  // How coefficient and coordinate values are drawn
  typedef enum int {MIX_FULL, MIX_SMALL, MIX_LIMIT} value_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [afft_pkg::FIELD_W-1:0] in_point_x = '0;
  logic signed [afft_pkg::FIELD_W-1:0] in_point_y = '0;
  logic signed [afft_pkg::FIELD_W-1:0] in_point_z = '0;
  logic out_valid;
  logic signed [afft_pkg::FIELD_W-1:0] out_moved_x;
  logic signed [afft_pkg::FIELD_W-1:0] out_moved_y;
  logic signed [afft_pkg::FIELD_W-1:0] out_moved_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [afft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [afft_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the matrix registers and the moved points still to come
  logic [afft_pkg::CFG_DATA_W-1:0] coef_regs [NUM_REGS];
  point_t pending_moves [$];
  int mismatch_count = 0;
  int idle_pct = 0;

  affine_point_transform_3d #(
    .FRAC_BITS  (FRAC),
    .COORD_WIDTH(CWIDTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .out_valid  (out_valid),
    .out_moved_x(out_moved_x),
    .out_moved_y(out_moved_y),
    .out_moved_z(out_moved_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // One matrix row applied to a point: exact sum, round half up, saturate
  function automatic logic signed [afft_pkg::FIELD_W-1:0] apply_row(
    input logic [afft_pkg::CFG_DATA_W-1:0] c01,
    input logic [afft_pkg::CFG_DATA_W-1:0] c23,
    input point_t p);
    logic signed [31:0] cx, cy, cz, tr;
    logic signed [63:0] prod;
    logic signed [79:0] acc;
    cx = c01[31:0];
    cy = c01[63:32];
    cz = c23[31:0];
    tr = c23[63:32];
    acc = 80'(tr) <<< FRAC;
    prod = 64'(cx) * 64'(p.x);
    acc = acc + 80'(prod);
    prod = 64'(cy) * 64'(p.y);
    acc = acc + 80'(prod);
    prod = 64'(cz) * 64'(p.z);
    acc = acc + 80'(prod);
    acc = (acc + (80'sd1 <<< (FRAC - 1))) >>> FRAC;
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return acc[afft_pkg::FIELD_W-1:0];
  endfunction

  function automatic point_t transform_point(input point_t p);
    point_t m;
    m.x = apply_row(coef_regs[afft_pkg::REG_ROW0_C01], coef_regs[afft_pkg::REG_ROW0_C23], p);
    m.y = apply_row(coef_regs[afft_pkg::REG_ROW1_C01], coef_regs[afft_pkg::REG_ROW1_C23], p);
    m.z = apply_row(coef_regs[afft_pkg::REG_ROW2_C01], coef_regs[afft_pkg::REG_ROW2_C23], p);
    return m;
  endfunction

  function automatic logic [31:0] rand_word(input value_mix_t mix);
    logic [31:0] v;
    case (mix)
      MIX_FULL: begin
        v = $urandom;
      end
      MIX_SMALL: begin
        v = $urandom_range(0, 1 << 19);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = Q_ONE;
          4: v = -Q_ONE;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Compare each strobed result with the oldest expected point
  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid) begin
      if (pending_moves.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h %h %h",
                                  out_moved_x, out_moved_y, out_moved_z));
      end else begin
        want = pending_moves.pop_front();
        if (out_moved_x !== want.x)
          report_mismatch($sformatf("moved_x got %h want %h", out_moved_x, want.x));
        if (out_moved_y !== want.y)
          report_mismatch($sformatf("moved_y got %h want %h", out_moved_y, want.y));
        if (out_moved_z !== want.z)
          report_mismatch($sformatf("moved_z got %h want %h", out_moved_z, want.z));
      end
    end
  end

  // Offer one point, idling first at random; returns right after the accepting edge
  task automatic send_point(input point_t p);
    @(negedge clk);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_point_x <= p.x;
    in_point_y <= p.y;
    in_point_z <= p.z;
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_moves.push_back(transform_point(p));
  endtask

  // Drop start and wait until every expected point has come back
  task automatic settle_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_coef_reg(input logic [afft_pkg::CFG_IDX_W-1:0] idx,
                                input logic [afft_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx <= afft_pkg::REG_ROW2_C23) coef_regs[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write a whole matrix; each row is c0, c1, c2, translation
  task automatic write_matrix(input logic [31:0] w [12]);
    for (int r = 0; r < afft_pkg::NUM_ROWS; r++) begin
      write_coef_reg(afft_pkg::reg_idx_t'(2 * r), {w[4 * r + 1], w[4 * r]});
      write_coef_reg(afft_pkg::reg_idx_t'(2 * r + 1), {w[4 * r + 3], w[4 * r + 2]});
    end
  endtask

  function automatic point_t make_point(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // Identity after reset must pass every point through unchanged
  task automatic test_reset_identity();
    send_point(make_point(Q_MAX, Q_MIN, '0));
    send_point(make_point(Q_MIN, Q_MAX, 32'hFFFF_FFFF));
    send_point(make_point('0, 32'h1, Q_ONE));
    send_point(make_point(32'hFFFF_FFFF, -Q_ONE, Q_MAX));
    send_point(make_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0));
    settle_pipeline();
  endtask

  // Drive the sums past both ends of the range
  task automatic test_saturation();
    logic [31:0] w [12];
    for (int k = 0; k < 12; k++) w[k] = Q_MAX;
    write_matrix(w);
    send_point(make_point(Q_MAX, Q_MAX, Q_MAX));
    send_point(make_point(Q_MIN, Q_MIN, Q_MIN));
    settle_pipeline();
    for (int k = 0; k < 12; k++) w[k] = Q_MIN;
    write_matrix(w);
    send_point(make_point(Q_MIN, Q_MIN, Q_MIN));
    send_point(make_point(Q_MAX, Q_MAX, Q_MAX));
    settle_pipeline();
  endtask

  // Exact halves must round up, toward plus infinity
  task automatic test_half_rounding();
    logic [31:0] w [12];
    for (int k = 0; k < 12; k++) w[k] = '0;
    w[0] = Q_HALF;
    w[5] = -Q_HALF;
    w[10] = Q_HALF;
    w[11] = Q_MIN;
    write_matrix(w);
    send_point(make_point(32'd1, 32'd1, 32'd1));
    send_point(make_point(-32'd1, -32'd1, -32'd1));
    send_point(make_point(32'd3, 32'd3, 32'd3));
    send_point(make_point(-32'd3, -32'd3, -32'd3));
    settle_pipeline();
  endtask

  // Writes to the two spare indexes must leave the matrix alone
  task automatic test_spare_index();
    write_coef_reg(IDX_SPARE_LO, {$urandom, $urandom});
    write_coef_reg(IDX_SPARE_HI, {$urandom, $urandom});
    send_point(make_point(32'h0003_8000, 32'hFFFD_0001, 32'h0100_0000));
    send_point(make_point(32'h8765_4321, 32'h0000_7FFF, 32'hFFFF_8000));
    settle_pipeline();
  endtask

  // Random matrices and points over several idling phases
  task automatic test_random_stream();
    logic [31:0] w [12];
    value_mix_t coef_mix;
    value_mix_t pt_mix;
    int pct_table [3];
    pct_table = '{0, 54, 6};
    for (int ph = 0; ph < 6; ph++) begin
      coef_mix = value_mix_t'((ph + ph / 3) % 3);
      for (int k = 0; k < 12; k++) w[k] = rand_word(coef_mix);
      idle_pct = 0;
      write_matrix(w);
      idle_pct = pct_table[ph % 3];
      for (int n = 0; n < PHASE_PTS; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pt_mix = MIX_FULL;
          4: pt_mix = MIX_LIMIT;
          default: pt_mix = MIX_SMALL;
        endcase
        send_point(make_point(rand_word(pt_mix), rand_word(pt_mix), rand_word(pt_mix)));
      end
      settle_pipeline();
    end
    idle_pct = 0;
  endtask

  // Run the tests in turn and give the verdict
  initial begin
    coef_regs[afft_pkg::REG_ROW0_C01] = 64'(Q_ONE);
    coef_regs[afft_pkg::REG_ROW0_C23] = '0;
    coef_regs[afft_pkg::REG_ROW1_C01] = {Q_ONE, 32'h0};
    coef_regs[afft_pkg::REG_ROW1_C23] = '0;
    coef_regs[afft_pkg::REG_ROW2_C01] = '0;
    coef_regs[afft_pkg::REG_ROW2_C23] = 64'(Q_ONE);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_identity();
    test_saturation();
    test_half_rounding();
    test_spare_index();
    test_random_stream();
    if (pending_moves.size() != 0)
      report_mismatch($sformatf("%0d results never came", pending_moves.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
